// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands, sampled on the rising edge of clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every sampled edge
`define EPX_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EPX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/epx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epx_pkg
// shared types and constants of the epx pixel doubler
// ----------------------------------------------------------------------------
package epx_pkg;

   localparam int PIX_W       = 16;
   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMOOTH_MODE = 1'd1;

   localparam logic [CSR_DATA_W-1:0] LINE_WIDTH_RESET = 10'd256;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type pixel_in;
      logic      frame_start;
   } req_item_type;

   typedef struct packed {
      pixel_type out_top_left;
      pixel_type out_top_right;
      pixel_type out_bottom_left;
      pixel_type out_bottom_right;
      logic      row_end;
   } rsp_item_type;

   // the 3x3 cross around the centre pixel, handed to the corner unit
   typedef struct packed {
      pixel_type centre;
      pixel_type left;
      pixel_type right;
      pixel_type up;
      pixel_type down;
   } cross_type;

endpackage

// ===== design/epx_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epx_stream_if
// valid/ready stream channel carrying one item per handshake
// ----------------------------------------------------------------------------
interface epx_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/epx_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epx_line_ram
// one line store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module epx_line_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                clock,
   input  logic                write_en,
   input  logic [AW-1:0]       write_addr,
   input  epx_pkg::pixel_type  write_data,
   input  logic                read_en,
   input  logic [AW-1:0]       read_addr,
   output epx_pkg::pixel_type  read_data
);

   epx_pkg::pixel_type mem_ff [DEPTH];
   epx_pkg::pixel_type rd_data_ff;

   // read before write when both ports hit the same entry
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         rd_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = rd_data_ff;

endmodule

// ===== design/epx_corner_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epx_corner_unit
// epx rule: builds the 2x2 block of the centre pixel from its four neighbors
// ----------------------------------------------------------------------------
module epx_corner_unit (
   input  epx_pkg::cross_type  cross_pix,
   input  logic                smooth_mode,
   output epx_pkg::pixel_type  top_left,
   output epx_pkg::pixel_type  top_right,
   output epx_pkg::pixel_type  bottom_left,
   output epx_pkg::pixel_type  bottom_right
);

   localparam epx_pkg::pixel_type AVG_MASK = 16'h7BDE;

   // rgb555 average without carries between channels
   function automatic epx_pkg::pixel_type blend555(input epx_pkg::pixel_type p,
                                                   input epx_pkg::pixel_type q);
      epx_pkg::pixel_type half_diff;
      half_diff = ((p ^ q) & AVG_MASK) >> 1;
      return (p & q) + half_diff;
   endfunction

   epx_pkg::pixel_type x;
   epx_pkg::pixel_type a;
   epx_pkg::pixel_type r;
   epx_pkg::pixel_type d;
   epx_pkg::pixel_type b;
   epx_pkg::pixel_type val_d;
   epx_pkg::pixel_type val_r;
   epx_pkg::pixel_type val_a;
   epx_pkg::pixel_type val_b;
   logic               active;

   always_comb begin
      x = cross_pix.centre;
      a = cross_pix.left;
      r = cross_pix.right;
      d = cross_pix.up;
      b = cross_pix.down;
      active = (a != r) && (d != b);
      val_d = smooth_mode ? blend555(d, x) : d;
      val_r = smooth_mode ? blend555(r, x) : r;
      val_a = smooth_mode ? blend555(a, x) : a;
      val_b = smooth_mode ? blend555(b, x) : b;
      top_left     = (active && (d == a)) ? val_d : x;
      top_right    = (active && (r == d)) ? val_r : x;
      bottom_left  = (active && (a == b)) ? val_a : x;
      bottom_right = (active && (b == r)) ? val_b : x;
   end

endmodule

// ===== design/epx_pixel_doubler_unit.sv =====
`timescale 1ns / 1ps
// an accepted item passes the second-stage registers and the output register before its block shows on rsp_ch
// throughput: one item per cycle while rsp_ch takes its blocks; each line store gives one read and one write a cycle
// the centre row is read one column ahead into a three-pixel window
// rows with fewer than two stored rows above produce no result
// reset (synchronous, active high) clears counters, store roles and the window;
// line stores are not cleared and need no pass after reset
// ----------------------------------------------------------------------------
// epx_pixel_doubler_unit
// epx 2x upscaler with two line stores, a column window and an output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epx_pixel_doubler_unit #(
   parameter int MAX_WIDTH = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   epx_stream_if.sink                          req_ch,
   epx_stream_if.source                        rsp_ch,
   input  logic                                csr_write_en,
   input  logic [epx_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [epx_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = ($clog2(MAX_WIDTH + 1) > epx_pkg::CSR_DATA_W) ?
                       $clog2(MAX_WIDTH + 1) : epx_pkg::CSR_DATA_W;

   // configuration
   logic [epx_pkg::CSR_DATA_W-1:0] line_width_ff;
   logic                           smooth_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff  <= epx_pkg::LINE_WIDTH_RESET;
         smooth_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         if (csr_index == epx_pkg::CSR_LINE_WIDTH) begin
            line_width_ff <= csr_wdata;
         end else if (csr_index == epx_pkg::CSR_SMOOTH_MODE) begin
            smooth_mode_ff <= csr_wdata[0];
         end
      end
   end

   // input stage: column tracking and store addressing
   epx_pkg::req_item_type req_item;
   logic                  req_fire;
   logic                  req_ready;
   logic [AW-1:0]         col_ff;
   logic [AW-1:0]         col_in;
   logic [1:0]            rows_ff;
   logic [1:0]            rows_in;
   logic                  sel_ff;
   logic                  sel_in;
   epx_pkg::pixel_type    first_ff;
   logic [AW-1:0]         col_eff;
   logic [1:0]            rows_eff;
   logic [WW-1:0]         width_raw;
   logic [WW-1:0]         width_eff;
   logic                  is_last;
   logic                  is_emit;
   logic [AW-1:0]         ahead_addr;

   assign req_item = req_ch.payload;
   assign req_fire = req_ch.valid && req_ready;

   always_comb begin
      width_raw = WW'(line_width_ff);
      priority if (width_raw < WW'(2)) begin
         width_eff = WW'(2);
      end else if (width_raw > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = width_raw;
      end
      col_eff    = req_item.frame_start ? '0 : col_ff;
      rows_eff   = req_item.frame_start ? 2'd0 : rows_ff;
      is_last    = WW'(col_eff) >= (width_eff - WW'(1));
      is_emit    = rows_eff == 2'd2;
      ahead_addr = is_last ? col_eff : col_eff + AW'(1);
   end

   always_comb begin
      col_in  = col_ff;
      rows_in = rows_ff;
      sel_in  = sel_ff;
      if (req_fire) begin
         if (is_last) begin
            col_in  = '0;
            sel_in  = ~sel_ff;
            rows_in = (rows_eff == 2'd2) ? rows_eff : rows_eff + 2'd1;
         end else begin
            col_in  = col_eff + AW'(1);
            rows_in = rows_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         rows_ff <= 2'd0;
         sel_ff  <= 1'b0;
      end else begin
         col_ff  <= col_in;
         rows_ff <= rows_in;
         sel_ff  <= sel_in;
      end
   end

   // column zero of the row just written, read back as centre at the next row start
   always_ff @(posedge clock) begin
      if (req_fire && (col_eff == '0)) begin
         first_ff <= req_item.pixel_in;
      end
   end

   // line stores: the upper store is read and written at the column,
   // the centre store is read one column ahead
   epx_pkg::pixel_type a_rd;
   epx_pkg::pixel_type b_rd;

   epx_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_store_a (
      .clock      (clock),
      .write_en   (req_fire && !sel_ff),
      .write_addr (col_eff),
      .write_data (req_item.pixel_in),
      .read_en    (req_fire),
      .read_addr  (sel_ff ? ahead_addr : col_eff),
      .read_data  (a_rd)
   );

   epx_line_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_store_b (
      .clock      (clock),
      .write_en   (req_fire && sel_ff),
      .write_addr (col_eff),
      .write_data (req_item.pixel_in),
      .read_en    (req_fire),
      .read_addr  (sel_ff ? col_eff : ahead_addr),
      .read_data  (b_rd)
   );

   // second stage: window and epx rule
   logic               s1_valid_ff;
   epx_pkg::pixel_type s1_pix_ff;
   epx_pkg::pixel_type s1_first_ff;
   logic               s1_col0_ff;
   logic               s1_last_ff;
   logic               s1_emit_ff;
   logic               s1_sel_ff;
   logic               s1_adv;
   epx_pkg::pixel_type cen_ff;
   epx_pkg::pixel_type left_ff;
   epx_pkg::pixel_type up_rd;
   epx_pkg::pixel_type ahead_rd;
   epx_pkg::cross_type cross_pix;
   epx_pkg::pixel_type blk_tl;
   epx_pkg::pixel_type blk_tr;
   epx_pkg::pixel_type blk_bl;
   epx_pkg::pixel_type blk_br;

   logic                  out_valid_ff;
   epx_pkg::rsp_item_type out_item_ff;

   assign s1_adv    = !out_valid_ff || rsp_ch.ready;
   assign req_ready = !reset && (!s1_valid_ff || s1_adv);
   assign req_ch.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pix_ff   <= req_item.pixel_in;
         s1_first_ff <= first_ff;
         s1_col0_ff  <= col_eff == '0;
         s1_last_ff  <= is_last;
         s1_emit_ff  <= is_emit;
         s1_sel_ff   <= sel_ff;
      end
   end

   always_comb begin
      up_rd            = s1_sel_ff ? b_rd : a_rd;
      ahead_rd         = s1_sel_ff ? a_rd : b_rd;
      cross_pix.centre = s1_col0_ff ? s1_first_ff : cen_ff;
      cross_pix.left   = s1_col0_ff ? cross_pix.centre : left_ff;
      cross_pix.right  = s1_last_ff ? cross_pix.centre : ahead_rd;
      cross_pix.up     = up_rd;
      cross_pix.down   = s1_pix_ff;
   end

   // window slides by one column as each item leaves the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff  <= '0;
         left_ff <= '0;
      end else if (s1_valid_ff && s1_adv) begin
         cen_ff  <= ahead_rd;
         left_ff <= cross_pix.centre;
      end
   end

   epx_corner_unit u_corner (
      .cross_pix    (cross_pix),
      .smooth_mode  (smooth_mode_ff),
      .top_left     (blk_tl),
      .top_right    (blk_tr),
      .bottom_left  (blk_bl),
      .bottom_right (blk_br)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_valid_ff && s1_emit_ff) begin
         out_item_ff.out_top_left     <= blk_tl;
         out_item_ff.out_top_right    <= blk_tr;
         out_item_ff.out_bottom_left  <= blk_bl;
         out_item_ff.out_bottom_right <= blk_br;
         out_item_ff.row_end          <= s1_last_ff;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.payload = out_item_ff;

   `EPX_ASSERT_ALWAYS(a_rows_saturate, rows_ff != 2'd3, "row count ran past two")
   `EPX_ASSERT_NEXT(a_row_wrap, req_fire && is_last,
                    (col_ff == '0) && (sel_ff != $past(sel_ff)),
                    "row end did not reset column and swap stores")
   `EPX_ASSERT_ALWAYS(a_empty_stage_ready, !s1_valid_ff |-> req_ready,
                      "input stalled with empty second stage")

endmodule

// ===== test/epx_block_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epx_block_checker
// watches both channels of the pixel doubler, predicts each 2x2 block from
// its own copy of the line stores and settings, and compares field by field
// ----------------------------------------------------------------------------
module epx_block_checker
   import epx_pkg::*;
#(
   parameter int MAX_WIDTH = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  req_item_type           req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rsp_item_type           rsp_item,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     mismatch_count,
   output int                     blocks_outstanding
);

   localparam pixel_type RGB555_HALF_MASK = 16'h7BDE;

   pixel_type              line_store [2][MAX_WIDTH];
   bit                     upper_sel;
   logic [9:0]             col_count;
   logic [1:0]             rows_seen;
   logic [CSR_DATA_W-1:0]  width_reg;
   bit                     smooth;
   rsp_item_type           expected_blocks [$];

   function automatic pixel_type rgb555_mean(pixel_type p, pixel_type q);
      return (p & q) + (((p ^ q) & RGB555_HALF_MASK) >> 1);
   endfunction

   function automatic pixel_type corner_pixel(pixel_type nb, pixel_type ctr);
      return smooth ? rgb555_mean(nb, ctr) : nb;
   endfunction

   task automatic take_pixel(input req_item_type item);
      int unsigned  w;
      int unsigned  c;
      int unsigned  ci;
      bit           last;
      bit           centre_sel;
      pixel_type    x;
      pixel_type    a;
      pixel_type    r;
      pixel_type    d;
      pixel_type    b;
      rsp_item_type blk;
      if (item.frame_start) begin
         col_count = '0;
         rows_seen = '0;
      end
      w = width_reg;
      if (w < 2) w = 2;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      c = col_count;
      last = (c >= w - 1);
      ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
      centre_sel = ~upper_sel;
      if (rows_seen == 2'd2) begin
         x = line_store[centre_sel][ci];
         // centre pixel stands in for the missing neighbour at either edge
         a = (ci == 0) ? x : line_store[centre_sel][ci - 1];
         r = last ? x : line_store[centre_sel][ci + 1];
         d = line_store[upper_sel][ci];
         b = item.pixel_in;
         blk = '{x, x, x, x, last};
         if (a != r && d != b) begin
            if (d == a) blk.out_top_left     = corner_pixel(d, x);
            if (r == d) blk.out_top_right    = corner_pixel(r, x);
            if (a == b) blk.out_bottom_left  = corner_pixel(a, x);
            if (b == r) blk.out_bottom_right = corner_pixel(b, x);
         end
         expected_blocks.push_back(blk);
      end
      line_store[upper_sel][ci] = item.pixel_in;
      if (last) begin
         col_count = '0;
         upper_sel = ~upper_sel;
         if (rows_seen < 2'd2) rows_seen++;
      end else begin
         col_count = 10'(c + 1);
      end
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         upper_sel = 1'b0;
         col_count = '0;
         rows_seen = '0;
         width_reg = LINE_WIDTH_RESET;
         smooth    = 1'b0;
         expected_blocks.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_LINE_WIDTH) width_reg = csr_wdata;
            else if (csr_index == CSR_SMOOTH_MODE) smooth = csr_wdata[0];
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_blocks.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected block, expected none, actual %h", $time, rsp_item);
            end else begin
               want = expected_blocks.pop_front();
               check_field("out_top_left", want.out_top_left, rsp_item.out_top_left);
               check_field("out_top_right", want.out_top_right, rsp_item.out_top_right);
               check_field("out_bottom_left", want.out_bottom_left,
                           rsp_item.out_bottom_left);
               check_field("out_bottom_right", want.out_bottom_right,
                           rsp_item.out_bottom_right);
               check_field("row_end", 16'(want.row_end), 16'(rsp_item.row_end));
            end
         end
         if (req_valid && req_ready) take_pixel(req_item);
      end
      blocks_outstanding = expected_blocks.size();
   end

endmodule

// ===== test/tb_epx_pixel_doubler_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epx_pixel_doubler_unit
// drives pixel frames, register writes and back-pressure into the doubler;
// a short hand-made pattern first, then random frames of mostly small widths
// with one long stalled frame, truncated frames, stray frame starts and
// narrowing of the line inside a frame; the checker does the comparing
// ----------------------------------------------------------------------------
module tb_epx_pixel_doubler_unit;
   import epx_pkg::*;

   localparam int MAX_WIDTH      = 512;
   localparam int RANDOM_ITEMS   = 950;
   localparam int HOLD_CYCLES    = 300;
   localparam int PRESSURE_WIDTH = 96;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TIMEOUT_NS     = 1_000_000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   int                     error_count;
   int                     blocks_pending;
   bit                     calm;
   bit                     hold_request;
   int                     gap_odds;
   int                     clamped_width;
   int                     random_sent;
   pixel_type              palette [4];

   // corner patterns at the smallest width, then at width three
   pixel_type narrow_grid [8] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                                  16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF};
   pixel_type wide_grid [15] = '{16'h8000, 16'hFFFF, 16'h0001,
                                 16'hFFFF, 16'h1234, 16'h0000,
                                 16'h0000, 16'h0000, 16'h1234,
                                 16'h7FFF, 16'h0000, 16'hABCD,
                                 16'h5555, 16'hAAAA, 16'hFFFF};

   epx_stream_if #(.payload_type(req_item_type)) req_ch ();
   epx_stream_if #(.payload_type(rsp_item_type)) rsp_ch ();

   epx_pixel_doubler_unit #(.MAX_WIDTH(MAX_WIDTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   epx_block_checker #(.MAX_WIDTH(MAX_WIDTH)) doubler_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_ch.valid),
      .req_ready          (req_ch.ready),
      .req_item           (req_ch.payload),
      .rsp_valid          (rsp_ch.valid),
      .rsp_ready          (rsp_ch.ready),
      .rsp_item           (rsp_ch.payload),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (error_count),
      .blocks_outstanding (blocks_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic pixel_type next_pixel();
      return ($urandom_range(0, 3) == 0) ? pixel_type'($urandom) : palette[$urandom_range(0, 3)];
   endfunction

   task automatic send_pixel(input pixel_type pix, input bit first);
      if (gap_odds != 0 && !calm && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= req_item_type'{pixel_in: pix, frame_start: first};
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (blocks_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_width(input int v);
      write_csr(CSR_LINE_WIDTH, CSR_DATA_W'(v));
      clamped_width = (v < 2) ? 2 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
   endtask

   // upper data bits are junk on purpose, only bit 0 counts
   task automatic set_smooth(input bit s);
      logic [CSR_DATA_W-1:0] data;
      data    = CSR_DATA_W'($urandom);
      data[0] = s;
      write_csr(CSR_SMOOTH_MODE, data);
   endtask

   initial begin
      bit hold_served;
      hold_served = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request && !hold_served) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_served = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int  kind;
      int  rows;
      int  total;
      int  n;
      int  v;
      bit  wide;
      bit  noisy;
      bit  big_done;
      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_LINE_WIDTH;
      csr_wdata      <= '0;
      calm          = 1'b0;
      hold_request  = 1'b0;
      gap_odds      = 0;
      clamped_width = LINE_WIDTH_RESET;
      random_sent   = 0;
      big_done      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // width zero acts as two
      set_width(0);
      set_smooth(1'b0);
      foreach (narrow_grid[i]) send_pixel(narrow_grid[i], i == 0);
      settle();
      set_width(3);
      set_smooth(1'b1);
      foreach (wide_grid[i]) send_pixel(wide_grid[i], i == 0);

      while (random_sent < RANDOM_ITEMS) begin
         settle();
         calm = (random_sent > RANDOM_ITEMS - 150);
         case ($urandom_range(0, 2))
            0:       gap_odds = 0;
            1:       gap_odds = 3;
            default: gap_odds = 8;
         endcase
         foreach (palette[i]) palette[i] = pixel_type'($urandom);
         if (!big_done && random_sent > RANDOM_ITEMS / 3) begin
            // three-row frame, receiver stalls during row three so the block fills
            big_done = 1'b1;
            set_width(PRESSURE_WIDTH);
            for (int i = 0; i < 3 * PRESSURE_WIDTH; i++) begin
               if (i == 2 * PRESSURE_WIDTH + 10) hold_request = 1'b1;
               send_pixel(next_pixel(), i == 0);
            end
            random_sent += 3 * PRESSURE_WIDTH;
         end else if ($urandom_range(0, 6) == 0) begin
            // narrow the line inside the current frame, column may sit past the new end
            v = $urandom_range(0, (clamped_width < 12) ? clamped_width : 12);
            set_width(v);
            n = clamped_width * $urandom_range(1, 4) + $urandom_range(0, 2);
            repeat (n) send_pixel(next_pixel(), 1'b0);
            random_sent += n;
         end else begin
            if (clamped_width > 40 || $urandom_range(0, 2) == 0) begin
               kind = $urandom_range(0, 19);
               case (kind)
                  0:       v = 0;
                  1:       v = 1;
                  2:       v = MAX_WIDTH;
                  3:       v = 1023;
                  4, 5, 6: v = $urandom_range(13, 40);
                  default: v = $urandom_range(2, 12);
               endcase
               set_width(v);
            end
            if ($urandom_range(0, 2) == 0) set_smooth(1'($urandom_range(0, 1)));
            wide  = clamped_width > 40;
            rows  = $urandom_range(3, 7);
            total = wide ? $urandom_range(20, 60) : rows * clamped_width;
            if ($urandom_range(0, 5) == 0) total = $urandom_range(1, total);
            noisy = $urandom_range(0, 7) == 0;
            for (int i = 0; i < total; i++)
               send_pixel(next_pixel(), i == 0 || (noisy && $urandom_range(0, 15) == 0));
            random_sent += total;
         end
      end

      settle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
